// ===== rtl/rpcd_pkg.sv =====
package rpcd_pkg;

   localparam int TIME_W     = 32;
   localparam int CODE_W     = 32;
   localparam int POS_W      = 6;
   localparam int INDEX_W    = 2;
   localparam int HIGH_W     = 16;
   localparam int GAP_W      = 20;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int MAX_KEYS   = 4;
   localparam int WORD_BITS  = 32;

   // register map, one 32-bit word per register
   typedef enum logic [2:0] {
      REG_KEY_CODE_0  = 3'd0,
      REG_KEY_CODE_1  = 3'd1,
      REG_KEY_CODE_2  = 3'd2,
      REG_KEY_CODE_3  = 3'd3,
      REG_LONG_HIGH   = 3'd4,
      REG_SHORT_HIGH  = 3'd5,
      REG_FRAME_GAP   = 3'd6,
      REG_MIN_LOW     = 3'd7
   } csr_index_type;

   typedef logic [CODE_W-1:0] key_reset_type [MAX_KEYS];

   localparam key_reset_type KEY_RESET = '{
      32'd6342651, 32'd3196923, 32'd25217019, 32'd12634107
   };
   localparam logic [HIGH_W-1:0] LONG_HIGH_RESET  = 16'd700;
   localparam logic [HIGH_W-1:0] SHORT_HIGH_RESET = 16'd100;
   localparam logic [GAP_W-1:0]  FRAME_GAP_RESET  = 20'd5000;
   localparam logic [HIGH_W-1:0] MIN_LOW_RESET    = 16'd700;

   // timing thresholds handed from the register block to the decoder
   typedef struct packed {
      logic [HIGH_W-1:0] long_high_us;
      logic [HIGH_W-1:0] short_high_us;
      logic [GAP_W-1:0]  frame_gap_us;
      logic [HIGH_W-1:0] min_low_us;
   } thresh_type;

endpackage

// ===== rtl/rpcd_intf.sv =====
interface rpcd_req_if;
   logic        valid;
   logic        ready;
   logic        level;
   logic [31:0] time_us;

   modport source (output valid, output level, output time_us, input ready);
   modport sink   (input valid, input level, input time_us, output ready);
endinterface

interface rpcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  key_index;
   logic [31:0] frame_code;

   modport source (output valid, output key_index, output frame_code, input ready);
   modport sink   (input valid, input key_index, input frame_code, output ready);
endinterface

// ===== rtl/rpcd_csr.sv =====
module rpcd_csr
   import rpcd_pkg::*;
#(
   parameter int KEY_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [CODE_W-1:0] key_code [KEY_COUNT],
   output thresh_type        thresh
);

   logic [CODE_W-1:0] key_ff [KEY_COUNT];
   logic [CODE_W-1:0] key_view [MAX_KEYS];
   thresh_type        thresh_ff;
   logic              wr_en;
   csr_index_type     wr_index;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite;
   assign wr_index = csr_index_type'(paddr[4:2]);

   for (genvar g = 0; g < MAX_KEYS; g++) begin : g_view
      if (g < KEY_COUNT) begin : g_real
         assign key_view[g] = key_ff[g];
      end else begin : g_none
         assign key_view[g] = '0;
      end
   end

   for (genvar g = 0; g < KEY_COUNT; g++) begin : g_key
      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[g] <= KEY_RESET[g];
         end else if (wr_en && (paddr[4:2] == 3'(g))) begin
            key_ff[g] <= pwdata;
         end
      end
      assign key_code[g] = key_ff[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.long_high_us  <= LONG_HIGH_RESET;
         thresh_ff.short_high_us <= SHORT_HIGH_RESET;
         thresh_ff.frame_gap_us  <= FRAME_GAP_RESET;
         thresh_ff.min_low_us    <= MIN_LOW_RESET;
      end else if (wr_en) begin
         unique case (wr_index)
            REG_LONG_HIGH:  thresh_ff.long_high_us  <= pwdata[HIGH_W-1:0];
            REG_SHORT_HIGH: thresh_ff.short_high_us <= pwdata[HIGH_W-1:0];
            REG_FRAME_GAP:  thresh_ff.frame_gap_us  <= pwdata[GAP_W-1:0];
            REG_MIN_LOW:    thresh_ff.min_low_us    <= pwdata[HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   assign thresh = thresh_ff;

   always_comb begin
      unique case (csr_index_type'(paddr[4:2]))
         REG_KEY_CODE_0: prdata = key_view[0];
         REG_KEY_CODE_1: prdata = key_view[1];
         REG_KEY_CODE_2: prdata = key_view[2];
         REG_KEY_CODE_3: prdata = key_view[3];
         REG_LONG_HIGH:  prdata = DATA_W'(thresh_ff.long_high_us);
         REG_SHORT_HIGH: prdata = DATA_W'(thresh_ff.short_high_us);
         REG_FRAME_GAP:  prdata = DATA_W'(thresh_ff.frame_gap_us);
         REG_MIN_LOW:    prdata = DATA_W'(thresh_ff.min_low_us);
         default:        prdata = '0;
      endcase
   end

endmodule

// ===== rtl/rpcd_core.sv =====
module rpcd_core
   import rpcd_pkg::*;
#(
   parameter int KEY_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CODE_W-1:0] key_code [KEY_COUNT],
   input  thresh_type        thresh,
   rpcd_req_if.sink          req_ch,
   rpcd_rsp_if.source        rsp_ch
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic              level_ff;
   logic [TIME_W-1:0] time_ff;

   // decoder state
   logic [TIME_W-1:0] rise_ff, rise_in;
   logic [TIME_W-1:0] fall_ff, fall_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CODE_W-1:0] word_ff, word_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [CODE_W-1:0]  code_ff;

   logic              in_accept;
   logic              advance;
   logic              work;
   logic              found;
   logic [TIME_W-1:0] dt_rise;
   logic [TIME_W-1:0] dt_fall;

   // the result register frees when empty or taken this cycle
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign work         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_accept    = req_ch.valid && req_ch.ready;
   assign in_valid_in  = in_accept || (in_valid_ff && !work);

   assign dt_rise = time_ff - rise_ff;
   assign dt_fall = time_ff - fall_ff;

   always_comb begin
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      pos_in   = pos_ff;
      word_in  = word_ff;
      found    = 1'b0;
      index_in = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (word_ff == key_code[k]) begin
            found    = 1'b1;
            index_in = INDEX_W'(k);
         end
      end
      if (work) begin
         if (!level_ff) begin
            if (dt_rise > TIME_W'(thresh.long_high_us)) begin
               fall_in = time_ff;
               if (pos_ff < POS_W'(WORD_BITS)) begin
                  word_in = word_ff | (CODE_W'(1) << pos_ff[4:0]);
                  pos_in  = pos_ff + POS_W'(1);
               end
            end else if (dt_rise > TIME_W'(thresh.short_high_us)) begin
               fall_in = time_ff;
               if (pos_ff < POS_W'(WORD_BITS)) begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end else if (dt_fall > TIME_W'(thresh.frame_gap_us)) begin
            word_in = '0;
            pos_in  = '0;
         end else if (dt_fall > TIME_W'(thresh.min_low_us)) begin
            rise_in = time_ff;
         end
      end
   end

   // a result comes only from a rising edge that closes a frame with a match
   assign rsp_valid_in = advance ? (work && level_ff && found &&
                                    (dt_fall > TIME_W'(thresh.frame_gap_us)))
                                 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         pos_ff       <= '0;
         word_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         pos_ff       <= pos_in;
         word_ff      <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         level_ff <= req_ch.level;
         time_ff  <= req_ch.time_us;
      end
      if (work) begin
         index_ff <= index_in;
         code_ff  <= word_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.key_index  = index_ff;
   assign rsp_ch.frame_code = code_ff;

endmodule

// ===== rtl/remote_pulse_code_decoder_top.sv =====
// Remote pulse-code decoder. Each transfer on req_ch is one edge of the
// receiver line (level after the edge, 32-bit microsecond timestamp, wrapping).
// A falling edge grades the high pulse since the last accepted rise: above
// long_high_us appends a one, above short_high_us a zero, anything shorter is
// dropped; the word holds 32 bits, first bit at position 0, and further bits
// are dropped. A rising edge after more than frame_gap_us of low closes the
// frame: the word is compared with the key codes, a match gives one transfer
// on rsp_ch with the highest matching key index and the raw word, and the
// word is cleared either way. A shorter low gap above min_low_us just records
// the rise time. The block takes one edge per clock: an edge is captured in
// the input register, decoded against the stored state in one pass and
// written to the result register. Back-pressure on rsp_ch stalls the input
// only while a result waits and the next edge is already held. Registers sit
// on an APB port at byte address 4*index, always ready; write them only while
// the block is idle.
module remote_pulse_code_decoder_top
   import rpcd_pkg::*;
#(
   parameter int KEY_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   rpcd_req_if.sink          req_ch,
   rpcd_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [CODE_W-1:0] key_code [KEY_COUNT];
   thresh_type        thresh;

   // register block: key codes and timing thresholds
   rpcd_csr #(
      .KEY_COUNT (KEY_COUNT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .key_code (key_code),
      .thresh   (thresh)
   );

   // edge decoder: input register, single-pass decode, result register
   rpcd_core #(
      .KEY_COUNT (KEY_COUNT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .key_code (key_code),
      .thresh   (thresh),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== rtl/rpcd_checker.sv =====
module rpcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_key_index,
   input logic [31:0] rsp_frame_code
);

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_key_index) && $stable(rsp_frame_code))
      else $error("result payload changed while stalled");

   // input stalls only behind a result that is not being taken
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // a fresh result follows an edge transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a preceding edge");

endmodule

bind remote_pulse_code_decoder_top rpcd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_key_index  (rsp_ch.key_index),
   .rsp_frame_code (rsp_ch.frame_code)
);

// ===== tb/sv/testbench.sv =====
module testbench;
   import rpcd_pkg::*;

   localparam int KEY_COUNT     = 4;
   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int IDLE_PERCENT  = 14;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_LIMIT  = 10;
   localparam int RUN_LIMIT     = 3_200_000;

   // one key result: the index that matched and the raw frame word
   typedef struct packed {
      logic [INDEX_W-1:0] key_index;
      logic [CODE_W-1:0]  frame_code;
   } key_hit_t;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   rpcd_req_if req_ch ();
   rpcd_rsp_if rsp_ch ();

   remote_pulse_code_decoder_top #(.KEY_COUNT(KEY_COUNT)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // register copies, zero-extended to 32 bits for the interval compares
   logic [CODE_W-1:0] keys_cfg [MAX_KEYS];
   logic [31:0]       long_cfg;
   logic [31:0]       short_cfg;
   logic [31:0]       gap_cfg;
   logic [31:0]       min_low_cfg;

   // decoder state as the block should hold it
   logic [TIME_W-1:0] last_rise;
   logic [TIME_W-1:0] last_fall;
   int unsigned       bits_held;
   logic [CODE_W-1:0] frame_word;

   key_hit_t          pending_hits [$];
   logic [TIME_W-1:0] line_time;

   bit                steady;
   bit                hold_request;
   int unsigned       edges_sent;
   int unsigned       frames_sent;
   int unsigned       hits_seen;
   int unsigned       mismatches;

   initial begin : clock_gen
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Run-time guard: end the run if anything hangs.
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Edge decoder prediction. Work out what one accepted edge does to the
   // frame state and queue the key result it causes, if any.
   // ------------------------------------------------------------------
   function automatic void decode_edge(logic rising, logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0]  span;
      logic [INDEX_W-1:0] best;
      key_hit_t           hit_rec;
      bit                 hit;
      int                 k;
      hit  = 1'b0;
      best = '0;
      if (!rising) begin
         // grade the high pulse since the last recorded rise
         span = stamp - last_rise;
         if (span > long_cfg || span > short_cfg) begin
            // hold the word once it is full
            if (bits_held < WORD_BITS) begin
               if (span > long_cfg) frame_word[bits_held] = 1'b1;
               bits_held++;
            end
            last_fall = stamp;
         end
      end else begin
         span = stamp - last_fall;
         if (span > gap_cfg) begin
            // frame end: highest matching key wins, then clear regardless
            for (k = 0; k < KEY_COUNT; k++) begin
               if (frame_word == keys_cfg[k]) begin
                  hit  = 1'b1;
                  best = INDEX_W'(k);
               end
            end
            if (hit) begin
               hit_rec.key_index  = best;
               hit_rec.frame_code = frame_word;
               pending_hits.push_back(hit_rec);
            end
            frame_word = '0;
            bits_held  = 0;
         end else if (span > min_low_cfg) begin
            last_rise = stamp;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Pulse and gap lengths drawn against the current thresholds
   // ------------------------------------------------------------------
   function automatic logic [TIME_W-1:0] one_high();
      return long_cfg + 1 + $urandom_range(300);
   endfunction

   function automatic logic [TIME_W-1:0] zero_high();
      // with short not below long no zero can be decoded; send a one instead
      if (short_cfg < long_cfg) return $urandom_range(long_cfg, short_cfg + 1);
      return long_cfg + 1;
   endfunction

   function automatic logic [TIME_W-1:0] bit_low();
      if (gap_cfg > min_low_cfg) return $urandom_range(gap_cfg, min_low_cfg + 1);
      return min_low_cfg + 1;
   endfunction

   function automatic logic [TIME_W-1:0] gap_low();
      return gap_cfg + 1 + $urandom_range(3000);
   endfunction

   function automatic logic [TIME_W-1:0] noise_span();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 4) return $urandom_range(3);
      if (pick < 7) return $urandom_range(2 * gap_cfg + 2);
      // random 32-bit jump: may wrap the timestamp
      return $urandom;
   endfunction

   function automatic int code_length(logic [CODE_W-1:0] code);
      int n;
      int i;
      n = 1;
      for (i = 0; i < CODE_W; i++) begin
         if (code[i]) n = i + 1;
      end
      return n;
   endfunction

   // ------------------------------------------------------------------
   // Key result monitor. Check each result transfer against the oldest
   // prediction and drive rsp ready, with random stalls and one long
   // hold-off on request.
   // ------------------------------------------------------------------
   initial begin : result_monitor
      key_hit_t want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: key %0d code %h",
                           rsp_ch.key_index, rsp_ch.frame_code);
            end else begin
               want = pending_hits.pop_front();
               hits_seen++;
               if (rsp_ch.key_index !== want.key_index ||
                   rsp_ch.frame_code !== want.frame_code) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: expected key %0d code %h, got key %0d code %h",
                              want.key_index, want.frame_code,
                              rsp_ch.key_index, rsp_ch.frame_code);
               end
            end
         end
         if (hold_request) begin
            // hold the result channel shut so the block fills and stalls its input
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Offer one edge and wait for its transfer; predict on acceptance.
   task automatic put_edge(logic rising, logic [TIME_W-1:0] stamp);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.level   <= rising;
      req_ch.time_us <= stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      decode_edge(rising, stamp);
      edges_sent++;
   endtask

   task automatic edge_after(logic rising, logic [TIME_W-1:0] span);
      line_time += span;
      put_edge(rising, line_time);
   endtask

   // APB write: setup, access, then psel goes low again before the next one.
   task automatic write_csr(csr_index_type index, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (index)
         REG_LONG_HIGH:  long_cfg    = 32'(value[HIGH_W-1:0]);
         REG_SHORT_HIGH: short_cfg   = 32'(value[HIGH_W-1:0]);
         REG_FRAME_GAP:  gap_cfg     = 32'(value[GAP_W-1:0]);
         REG_MIN_LOW:    min_low_cfg = 32'(value[HIGH_W-1:0]);
         default:        keys_cfg[index] = value;
      endcase
   endtask

   task automatic set_timing(logic [31:0] long_us, logic [31:0] short_us,
                             logic [31:0] gap_us, logic [31:0] min_low_us);
      write_csr(REG_LONG_HIGH, long_us);
      write_csr(REG_SHORT_HIGH, short_us);
      write_csr(REG_FRAME_GAP, gap_us);
      write_csr(REG_MIN_LOW, min_low_us);
   endtask

   // Random key codes up to max_width bits, usually odd since the first
   // bit after a frame gap always grades as a one.
   task automatic draw_keys(int max_width);
      logic [CODE_W-1:0] code;
      int                k;
      for (k = 0; k < KEY_COUNT; k++) begin
         code = $urandom;
         code = code >> (CODE_W - $urandom_range(max_width, 1));
         if ($urandom_range(9) != 0) code[0] = 1'b1;
         write_csr(csr_index_type'(k), code);
      end
   endtask

   // Drop valid, wait for every predicted result, then let the pipe drain.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic close_and_settle();
      edge_after(1'b1, gap_low());
      settle();
   endtask

   // One frame: closing rise, then a pulse per bit, LSB first. Glitches
   // are thrown in now and then; bits past the word width are random.
   task automatic send_frame(logic [CODE_W-1:0] code, int nbits);
      int i;
      bit one;
      edge_after(1'b1, gap_low());
      for (i = 0; i < nbits; i++) begin
         if (i > 0) edge_after(1'b1, bit_low());
         if ($urandom_range(99) < 4) edge_after(1'b0, $urandom_range(short_cfg, 0));
         one = (i < CODE_W) ? code[i] : $urandom_range(1);
         edge_after(1'b0, one ? one_high() : zero_high());
      end
      frames_sent++;
   endtask

   // Mostly well-formed frames for the stored keys; the rest corrupted,
   // overlong, empty or plain noise.
   task automatic run_frames(int unsigned budget);
      int unsigned       stop;
      int unsigned       pick;
      int                nbits;
      int                flip;
      logic [CODE_W-1:0] code;
      stop = edges_sent + budget;
      while (edges_sent < stop) begin
         pick = $urandom_range(99);
         code = keys_cfg[$urandom_range(KEY_COUNT - 1)];
         if (pick < 68) begin
            nbits = code_length(code) + $urandom_range(2);
            if (nbits > WORD_BITS) nbits = WORD_BITS;
            send_frame(code, nbits);
         end else if (pick < 78) begin
            flip       = $urandom_range(CODE_W - 1);
            code[flip] = ~code[flip];
            send_frame(code, code_length(code));
         end else if (pick < 85) begin
            send_frame($urandom, $urandom_range(40, 33));
         end else if (pick < 95) begin
            repeat ($urandom_range(6, 1)) edge_after($urandom_range(1), noise_span());
         end else begin
            // a bare closing rise; two in a row give an empty frame
            edge_after(1'b1, gap_low());
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Hand-built edges around every threshold, with reset timing.
   task automatic test_threshold_edges();
      write_csr(REG_KEY_CODE_0, 32'h0);
      write_csr(REG_KEY_CODE_1, 32'h1);
      write_csr(REG_KEY_CODE_2, 32'h5);
      write_csr(REG_KEY_CODE_3, 32'h5);
      line_time = '0;
      put_edge(1'b1, line_time);   // timestamp zero, no low time at all
      line_time = '1;
      put_edge(1'b0, line_time);   // top timestamp: very long high, a one
      edge_after(1'b1, 701);       // wraps through zero, low just over min_low
      edge_after(1'b0, 100);       // glitch of exactly short_high: ignored
      edge_after(1'b0, 600);       // high of exactly long_high: a zero
      edge_after(1'b1, 700);       // low of exactly min_low: no rise recorded
      edge_after(1'b1, 4300);      // low of exactly frame_gap: rise only
      edge_after(1'b0, 701);       // one, word is now 5
      edge_after(1'b1, 5001);      // frame end, keys 2 and 3 both match
      edge_after(1'b1, 5001);      // empty frame, matches key 0
      // the same frame twice: each gives its own result
      repeat (2) begin
         edge_after(1'b0, 50);
         edge_after(1'b1, 800);
         edge_after(1'b0, 101);
         edge_after(1'b1, 6000);
      end
      edge_after(1'b0, 701);
      edge_after(1'b1, 701);
      edge_after(1'b0, 701);
      edge_after(1'b1, 9000);      // word 3 matches nothing: cleared silently
      edge_after(1'b1, 0);         // same timestamp, closes an empty frame
      settle();
   endtask

   task automatic test_reset_codes();
      int k;
      for (k = 0; k < KEY_COUNT; k++) write_csr(csr_index_type'(k), KEY_RESET[k]);
      set_timing(LONG_HIGH_RESET, SHORT_HIGH_RESET, FRAME_GAP_RESET, MIN_LOW_RESET);
      run_frames(200);
      close_and_settle();
   endtask

   task automatic test_random_codes();
      draw_keys(CODE_W);
      run_frames(220);
      close_and_settle();
   endtask

   // Tight thresholds, and the long stretch with no idling on either side.
   task automatic test_tight_timing();
      set_timing(20, 5, 200, 10);
      draw_keys(16);
      steady = 1'b1;
      run_frames(200);
      close_and_settle();
      steady = 1'b0;
   endtask

   // All thresholds zero: every rise after any low closes a frame.
   task automatic test_zero_thresholds();
      set_timing(0, 0, 0, 0);
      write_csr(REG_KEY_CODE_0, 32'h0);
      write_csr(REG_KEY_CODE_1, 32'h1);
      write_csr(REG_KEY_CODE_2, 32'hFFFF_FFFF);
      write_csr(REG_KEY_CODE_3, 32'h1);
      run_frames(120);
      close_and_settle();
   endtask

   // Widest long, gap, min-low: all-ones, upper bits masked; short random.
   task automatic test_widest_thresholds();
      set_timing(32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      draw_keys(16);
      run_frames(120);
      close_and_settle();
   endtask

   // Short threshold above long: only ones can be decoded.
   task automatic test_inverted_thresholds();
      set_timing(300, 900, 3000, 200);
      draw_keys(12);
      run_frames(120);
      close_and_settle();
   endtask

   task automatic test_timestamp_wrap();
      set_timing(LONG_HIGH_RESET, SHORT_HIGH_RESET, FRAME_GAP_RESET, MIN_LOW_RESET);
      draw_keys(10);
      line_time = 32'hFFFF_FFFF - $urandom_range(20000);
      run_frames(80);
      close_and_settle();
   endtask

   // Hold the result side shut while short matching frames keep coming,
   // then pause the sender until every result is through.
   task automatic test_output_stall();
      write_csr(REG_KEY_CODE_0, 32'h1);
      write_csr(REG_KEY_CODE_1, 32'h3);
      write_csr(REG_KEY_CODE_2, 32'h7);
      write_csr(REG_KEY_CODE_3, 32'hF);
      steady       = 1'b1;
      hold_request = 1'b1;
      repeat (12) send_frame(32'hF, $urandom_range(4, 1));
      edge_after(1'b1, gap_low());
      steady = 1'b0;
      settle();
      run_frames(40);
      close_and_settle();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int k;
      // initialise the model to the reset register values
      for (k = 0; k < MAX_KEYS; k++) keys_cfg[k] = KEY_RESET[k];
      long_cfg     = 32'(LONG_HIGH_RESET);
      short_cfg    = 32'(SHORT_HIGH_RESET);
      gap_cfg      = 32'(FRAME_GAP_RESET);
      min_low_cfg  = 32'(MIN_LOW_RESET);
      last_rise    = '0;
      last_fall    = '0;
      bits_held    = 0;
      frame_word   = '0;
      line_time    = '0;
      steady       = 1'b0;
      hold_request = 1'b0;
      edges_sent   = 0;
      frames_sent  = 0;
      hits_seen    = 0;
      mismatches   = 0;

      // drive every input to a known value, then hold reset
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.level   <= 1'b0;
      req_ch.time_us <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_threshold_edges();
      test_reset_codes();
      test_random_codes();
      test_tight_timing();
      test_zero_thresholds();
      test_widest_thresholds();
      test_inverted_thresholds();
      test_timestamp_wrap();
      test_output_stall();

      $display("Run covered %0d edges in %0d generated frames; %0d key results checked.",
               edges_sent, frames_sent, hits_seen);
      $display("Timing sets: reset, tight, zero, widest, inverted; wrap and output stall.");
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== remote_pulse_code_decoder_top.f =====
rtl/rpcd_pkg.sv
rtl/rpcd_intf.sv
rtl/rpcd_csr.sv
rtl/rpcd_core.sv
rtl/remote_pulse_code_decoder_top.sv
rtl/rpcd_checker.sv
tb/sv/testbench.sv
